### hw/rtl/idv_pkg.sv
// Package for the ID number date and check digit validator.
// Holds widths, status codes and the digit helpers used by the converter
// and by the check stages. No dependencies.
`default_nettype none

package idv_pkg;

  localparam int unsigned IdBits       = 44;
  localparam int unsigned NumDigits    = 13;
  localparam int unsigned DigitBits    = 4;
  localparam int unsigned BcdBits      = NumDigits * DigitBits;
  localparam int unsigned BitsPerStage = 4;
  localparam int unsigned DabbleStages = IdBits / BitsPerStage;
  localparam int unsigned ConvStages   = DabbleStages + 1;
  localparam int unsigned SumBits      = 9;
  localparam int unsigned QuotBits     = 6;
  localparam int unsigned ModMul       = 186;
  localparam int unsigned ModShift     = 11;
  localparam int unsigned Modulus      = 11;

  localparam logic [IdBits-1:0] IdMaxValue = 44'd9999999999999;

  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_BAD_DATE  = 2'd1,
    ST_BAD_CHECK = 2'd2,
    ST_TOO_LONG  = 2'd3
  } idv_status_e;

  typedef struct packed {
    logic [IdBits-1:0]  bin;
    logic [BcdBits-1:0] bcd;
    logic               ovf;
  } idv_conv_t;

  typedef struct packed {
    logic [BcdBits-1:0] bcd;
    logic               ovf;
  } idv_digits_t;

  // d0 is the most significant digit
  function automatic logic [DigitBits-1:0] get_digit(input logic [BcdBits-1:0] bcd,
                                                     input int unsigned idx);
    return bcd[DigitBits*(NumDigits-1-idx) +: DigitBits];
  endfunction

  function automatic logic [BcdBits-1:0] dabble_step(input logic [BcdBits-1:0] bcd,
                                                     input logic bit_in);
    logic [BcdBits-1:0] adj;
    adj = bcd;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd[DigitBits*i +: DigitBits] >= 4'd5) begin
        adj[DigitBits*i +: DigitBits] = bcd[DigitBits*i +: DigitBits] + 4'd3;
      end
    end
    return {adj[BcdBits-2:0], bit_in};
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic date_check(input logic [BcdBits-1:0] bcd);
    logic [DigitBits-1:0] d0, d1, d2, d3, d4, d5, d6;
    logic [6:0]           day;
    logic [6:0]           month;
    logic [1:0]           low2;
    logic                 leap;
    logic [4:0]           limit;
    d0    = get_digit(bcd, 0);
    d1    = get_digit(bcd, 1);
    d2    = get_digit(bcd, 2);
    d3    = get_digit(bcd, 3);
    d4    = get_digit(bcd, 4);
    d5    = get_digit(bcd, 5);
    d6    = get_digit(bcd, 6);
    day   = {3'b000, d0} * 7'd10 + {3'b000, d1};
    month = {3'b000, d2} * 7'd10 + {3'b000, d3};
    // year mod 4 follows from 2*tens + ones
    low2  = {d5[0], 1'b0} + d6[1:0];
    leap  = ((low2 == 2'd0) && ((d5 != 4'd0) || (d6 != 4'd0))) ||
            ((d5 == 4'd0) && (d6 == 4'd0) && (d4[1:0] == 2'd0));
    limit = month_len(month[3:0]);
    if ((month == 7'd2) && leap) begin
      limit = limit + 5'd1;
    end
    return ({d4, d5, d6} != 12'd0) && (month >= 7'd1) && (month <= 7'd12) &&
           (day >= 7'd1) && (day <= {2'b00, limit});
  endfunction

  function automatic logic [SumBits-1:0] weighted_sum(input logic [BcdBits-1:0] bcd);
    logic [SumBits-1:0] acc;
    logic [4:0]         pair;
    acc = '0;
    for (int i = 0; i < 6; i++) begin
      pair = {1'b0, get_digit(bcd, i)} + {1'b0, get_digit(bcd, i + 6)};
      acc  = acc + {4'b0000, pair} * SumBits'(7 - i);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/idv_bin2bcd.sv
// Pipelined binary to BCD converter, four shift-add-3 steps per stage.
// Flags inputs above thirteen digits. Depends on idv_pkg.
`default_nettype none

module idv_bin2bcd
  import idv_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [IdBits-1:0] id_number_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output idv_digits_t            out_digits_o
);

  logic      valid_q [ConvStages];
  idv_conv_t stage_q [ConvStages];
  logic      en      [ConvStages];

  always_comb begin
    en[ConvStages-1] = !valid_q[ConvStages-1] || out_ready_i;
    for (int s = ConvStages - 2; s >= 0; s--) begin
      en[s] = !valid_q[s] || en[s+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en[0]) begin
      valid_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) begin
      stage_q[0].bin <= id_number_i;
      stage_q[0].bcd <= '0;
      stage_q[0].ovf <= id_number_i > IdMaxValue;
    end
  end

  for (genvar s = 1; s < ConvStages; s++) begin : g_stage
    idv_conv_t nxt;

    always_comb begin
      nxt = stage_q[s-1];
      for (int j = 0; j < BitsPerStage; j++) begin
        nxt.bcd = dabble_step(nxt.bcd, nxt.bin[IdBits-1]);
        nxt.bin = {nxt.bin[IdBits-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en[s]) begin
        valid_q[s] <= valid_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s] && valid_q[s-1]) begin
        stage_q[s] <= nxt;
      end
    end
  end

  assign out_valid_o      = valid_q[ConvStages-1];
  assign out_digits_o.bcd = stage_q[ConvStages-1].bcd;
  assign out_digits_o.ovf = stage_q[ConvStages-1].ovf;

endmodule

`default_nettype wire

### hw/rtl/id_number_date_and_check_digit_validator_unit.sv
// Top level of the ID number date and check digit validator.
// Pipeline from input accept to result valid: 12 conversion stages, then
// date/sum, quotient, remainder and status stages.
// Throughput: one item per cycle while out_ready_i is high; every stage advances
// when it is empty or its successor advances. Reset clears all stage valid bits.
// Depends on idv_pkg and idv_bin2bcd.
`default_nettype none

module id_number_date_and_check_digit_validator_unit
  import idv_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [IdBits-1:0] id_number_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   is_valid_o,
  output logic [1:0]             status_o
);

  typedef struct packed {
    logic                 date_ok;
    logic [SumBits-1:0]   sum;
    logic [DigitBits-1:0] check_digit;
    logic                 ovf;
  } idv_sum_t;

  typedef struct packed {
    logic                 date_ok;
    logic [SumBits-1:0]   sum;
    logic [QuotBits-1:0]  quot;
    logic [DigitBits-1:0] check_digit;
    logic                 ovf;
  } idv_quot_t;

  typedef struct packed {
    logic                 date_ok;
    logic [3:0]           rem;
    logic [DigitBits-1:0] check_digit;
    logic                 ovf;
  } idv_rem_t;

  logic        conv_valid;
  idv_digits_t conv_digits;

  logic        a_valid_q, b_valid_q, c_valid_q, d_valid_q;
  idv_sum_t    a_q;
  idv_quot_t   b_q;
  idv_rem_t    c_q;
  logic        is_valid_q;
  idv_status_e status_q;
  logic        en_a, en_b, en_c, en_d;

  logic [SumBits+8-1:0] prod;
  logic [SumBits-1:0]   q_times_m;
  logic [4:0]           rem_raw;
  logic [3:0]           rem_d;
  logic [3:0]           k;
  idv_status_e          status_d;

  idv_bin2bcd u_bin2bcd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .id_number_i (id_number_i),
    .out_valid_o (conv_valid),
    .out_ready_i (en_a),
    .out_digits_o(conv_digits)
  );

  assign en_d = !d_valid_q || out_ready_i;
  assign en_c = !c_valid_q || en_d;
  assign en_b = !b_valid_q || en_c;
  assign en_a = !a_valid_q || en_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (en_a) begin
        a_valid_q <= conv_valid;
      end
      if (en_b) begin
        b_valid_q <= a_valid_q;
      end
      if (en_c) begin
        c_valid_q <= b_valid_q;
      end
      if (en_d) begin
        d_valid_q <= c_valid_q;
      end
    end
  end

  // s mod 11 by reciprocal: quotient is low by at most one
  assign prod      = {8'd0, b_q.sum} * (SumBits + 8)'(ModMul);
  assign q_times_m = {3'b000, b_q.quot} * SumBits'(Modulus);
  assign rem_raw   = 5'(b_q.sum - q_times_m);
  assign rem_d     = (rem_raw >= 5'(Modulus)) ? 4'(rem_raw - 5'(Modulus)) : rem_raw[3:0];

  assign k = (c_q.rem == 4'd0) ? 4'd0 : 4'(4'(Modulus) - c_q.rem);

  always_comb begin
    if (c_q.ovf) begin
      status_d = ST_TOO_LONG;
    end else if (!c_q.date_ok) begin
      status_d = ST_BAD_DATE;
    end else if (k != c_q.check_digit) begin
      status_d = ST_BAD_CHECK;
    end else begin
      status_d = ST_VALID;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && conv_valid) begin
      a_q.date_ok     <= date_check(conv_digits.bcd);
      a_q.sum         <= weighted_sum(conv_digits.bcd);
      a_q.check_digit <= get_digit(conv_digits.bcd, NumDigits - 1);
      a_q.ovf         <= conv_digits.ovf;
    end
    if (en_b && a_valid_q) begin
      b_q.date_ok     <= a_q.date_ok;
      b_q.sum         <= a_q.sum;
      b_q.quot        <= QuotBits'(({8'd0, a_q.sum} * (SumBits + 8)'(ModMul)) >> ModShift);
      b_q.check_digit <= a_q.check_digit;
      b_q.ovf         <= a_q.ovf;
    end
    if (en_c && b_valid_q) begin
      c_q.date_ok     <= b_q.date_ok;
      c_q.rem         <= rem_d;
      c_q.check_digit <= b_q.check_digit;
      c_q.ovf         <= b_q.ovf;
    end
    if (en_d && c_valid_q) begin
      status_q   <= status_d;
      is_valid_q <= status_d == ST_VALID;
    end
  end

  assign out_valid_o = d_valid_q;
  assign is_valid_o  = is_valid_q;
  assign status_o    = status_q;

  ap_valid_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_valid_o == (status_o == ST_VALID)))
    else $error("is_valid disagrees with status");

  ap_too_long_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_d && c_valid_q && c_q.ovf) |=> (out_valid_o && status_o == ST_TOO_LONG))
    else $error("overlong number not reported");

  ap_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_c && b_valid_q) |-> (rem_d < 4'(Modulus) && prod[SumBits+8-1:ModShift] == b_q.quot))
    else $error("mod 11 remainder out of range");

endmodule

`default_nettype wire
